[hw/rtl/cbpe_pkg.sv]
// Shared constants and types for the cubic Bezier point evaluator.
package cbpe_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int NUM_POINTS          = 4;
  localparam int NUM_AXES            = 3;
  localparam int CFG_INDEX_BITS      = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_POINT   = 3'd0,
    REG_FIRST_HANDLE  = 3'd1,
    REG_SECOND_HANDLE = 3'd2,
    REG_END_POINT     = 3'd3
  } cfg_reg_t;

endpackage

[hw/rtl/cbpe_param_if.sv]
// Request channel carrying the curve parameter t.
interface cbpe_param_if #(
  parameter int PARAM_BITS = cbpe_pkg::PARAM_FRAC_BITS_DEF + 1
);
  logic                  valid;
  logic                  ready;
  logic [PARAM_BITS-1:0] curve_param;

  modport source (output valid, output curve_param, input ready);
  modport sink   (input valid, input curve_param, output ready);
endinterface

[hw/rtl/cbpe_point_if.sv]
// Result channel carrying one curve point.
interface cbpe_point_if #(
  parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

[hw/rtl/cbpe_weights.sv]
// Three-stage pipeline forming the weights k0..k3 from t: the Bernstein weights without the factor 3 on k1 and k2.
module cbpe_weights
  import cbpe_pkg::*;
#(
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [PARAM_FRAC_BITS:0]              in_t,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [NUM_POINTS-1:0][PARAM_FRAC_BITS:0] out_k
);

  localparam int F  = PARAM_FRAC_BITS;
  localparam int MW = 2*F + 2;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic           v0_r, v1_r, v2_r;
  logic           rdy0, rdy1, rdy2;
  logic [F:0]     t_cl, r_cl;
  logic [F:0]     t0_r, r0_r;
  logic [F:0]     t1_r, r1_r, tt1_r, rr1_r;
  logic [2*F+1:0] tt_full, rr_full;
  logic [2*F+1:0] k0_full, k1_full, k2_full, k3_full;
  logic [NUM_POINTS-1:0][F:0] k_r;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  assign t_cl = (in_t > ONE) ? ONE : in_t;
  assign r_cl = ONE - t_cl;

  assign tt_full = MW'(t0_r) * MW'(t0_r);
  assign rr_full = MW'(r0_r) * MW'(r0_r);

  assign k0_full = MW'(r1_r) * MW'(rr1_r);
  assign k1_full = MW'(rr1_r) * MW'(t1_r);
  assign k2_full = MW'(r1_r) * MW'(tt1_r);
  assign k3_full = MW'(tt1_r) * MW'(t1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      t0_r <= t_cl;
      r0_r <= r_cl;
    end
    if (rdy1 && v0_r) begin
      t1_r  <= t0_r;
      r1_r  <= r0_r;
      tt1_r <= tt_full[2*F:F];
      rr1_r <= rr_full[2*F:F];
    end
    if (rdy2 && v1_r) begin
      k_r[0] <= k0_full[2*F:F];
      k_r[1] <= k1_full[2*F:F];
      k_r[2] <= k2_full[2*F:F];
      k_r[3] <= k3_full[2*F:F];
    end
  end

  assign out_valid = v2_r;
  assign out_k     = k_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v0_r)
    else $error("accepted request did not reach first stage");

  a_t_plus_r: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> ((F+2)'(t0_r) + (F+2)'(r0_r) == (F+2)'(ONE)))
    else $error("t and 1-t do not sum to one");

  a_unit_square: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && t1_r == ONE) |-> (tt1_r == ONE && rr1_r == '0))
    else $error("square of t at one is wrong");

endmodule

[hw/rtl/cbpe_combine.sv]
// Three-stage pipeline: weighted products, sum, round and saturate per axis.
module cbpe_combine
  import cbpe_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [NUM_POINTS-1:0][PARAM_FRAC_BITS:0] in_k,
  input  logic [NUM_POINTS-1:0][3*COORD_BITS-1:0]  ctrl,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [COORD_BITS-1:0]             out_x,
  output logic signed [COORD_BITS-1:0]             out_y,
  output logic signed [COORD_BITS-1:0]             out_z
);

  localparam int C  = COORD_BITS;
  localparam int F  = PARAM_FRAC_BITS;
  localparam int PW = F + C + 2;
  localparam int SW = F + C + 5;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (F - 1);
  localparam logic signed [SW-1:0] HI   = SW'((64'd1 << (C - 1)) - 64'd1);
  localparam logic signed [SW-1:0] LO   = -HI - SW'(1);

  logic vA_r, vB_r, vC_r;
  logic rdyA, rdyB, rdyC;

  logic signed [PW-1:0] prod     [NUM_POINTS][NUM_AXES];
  logic signed [PW-1:0] prod_r   [NUM_POINTS][NUM_AXES];
  logic signed [SW-1:0] sum      [NUM_AXES];
  logic signed [SW-1:0] sum_r    [NUM_AXES];
  logic signed [SW-1:0] shifted  [NUM_AXES];
  logic signed [C-1:0]  sat      [NUM_AXES];
  logic signed [C-1:0]  pt_r     [NUM_AXES];

  assign rdyC     = !vC_r || out_ready;
  assign rdyB     = !vB_r || rdyC;
  assign rdyA     = !vA_r || rdyB;
  assign in_ready = rdyA;

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod[i][a] = PW'($signed({1'b0, in_k[i]})) * PW'($signed(ctrl[i][a*C +: C]));
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic signed [SW-1:0] mid;
      mid        = SW'(prod_r[1][a]) + SW'(prod_r[2][a]);
      sum[a]     = SW'(prod_r[0][a]) + SW'(prod_r[3][a]) + (mid <<< 1) + mid + HALF;
      shifted[a] = sum_r[a] >>> F;
      if (shifted[a] < LO)      sat[a] = LO[C-1:0];
      else if (shifted[a] > HI) sat[a] = HI[C-1:0];
      else                      sat[a] = shifted[a][C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vA_r <= 1'b0;
      vB_r <= 1'b0;
      vC_r <= 1'b0;
    end else begin
      if (rdyA) vA_r <= in_valid;
      if (rdyB) vB_r <= vA_r;
      if (rdyC) vC_r <= vB_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdyA && in_valid) prod_r <= prod;
    if (rdyB && vA_r)     sum_r  <= sum;
    if (rdyC && vB_r)     pt_r   <= sat;
  end

  assign out_valid = vC_r;
  assign out_x     = pt_r[0];
  assign out_y     = pt_r[1];
  assign out_z     = pt_r[2];

  a_sum_held: assert property (@(posedge clk) disable iff (!rst_n)
    (vB_r && !rdyC) |=> (vB_r && $stable(sum_r[0]) && $stable(sum_r[2])))
    else $error("stalled sum stage changed");

  a_prod_held: assert property (@(posedge clk) disable iff (!rst_n)
    (vA_r && !rdyB) |=> (vA_r && $stable(prod_r[3][1])))
    else $error("stalled product stage changed");

endmodule

[hw/rtl/cubic_bezier_point_evaluator_top.sv]
// Cubic Bezier point evaluator: top level with control point registers.
//
// Each request carries t (unsigned, 2^F means 1.0, larger values clamped) and
// yields one 3-D point on the cubic Bezier curve defined by the four control
// point registers, rounded half-up and saturated per axis. One point per cycle
// is sustained while results are taken; the work is done by the six-stage
// multiplier pipeline (t and 1-t, squares, cubic weights, weighted
// products, sum, round and saturate). A stalled result holds the pipeline in
// place: requests keep entering until all six stages are full, then in_req
// ready drops until the waiting result is taken. Control points are
// written through cfg_we/cfg_index/cfg_data (x in the low field, then y, z)
// and must only change while no request is in flight.
module cubic_bezier_point_evaluator_top
  import cbpe_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cbpe_param_if.sink                  in_req,
  cbpe_point_if.source                out_pt,
  input  logic                        cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [3*COORD_BITS-1:0]     cfg_data
);

  logic [NUM_POINTS-1:0][3*COORD_BITS-1:0] ctrl_r;
  logic [NUM_POINTS-1:0][PARAM_FRAC_BITS:0] k;
  logic k_valid, k_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_POINT:   ctrl_r[0] <= cfg_data;
        REG_FIRST_HANDLE:  ctrl_r[1] <= cfg_data;
        REG_SECOND_HANDLE: ctrl_r[2] <= cfg_data;
        REG_END_POINT:     ctrl_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  cbpe_weights #(
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_weights (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_t      (in_req.curve_param),
    .out_valid (k_valid),
    .out_ready (k_ready),
    .out_k     (k)
  );

  cbpe_combine #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (k_valid),
    .in_ready  (k_ready),
    .in_k      (k),
    .ctrl      (ctrl_r),
    .out_valid (out_pt.valid),
    .out_ready (out_pt.ready),
    .out_x     (out_pt.point_x),
    .out_y     (out_pt.point_y),
    .out_z     (out_pt.point_z)
  );

endmodule
